>>> hdl/trr_pkg.sv
`timescale 1ns / 1ps

package trr_pkg;

   // row geometry
   localparam int DOTS_PER_ROW     = 384;
   localparam int GRAPH_LEFT_DOT   = 32;
   localparam int GRAPH_RIGHT_DOT  = 376;
   localparam int GRAPH_CENTRE_DOT = 204;
   localparam int MAX_ROW_COUNT    = 2048;

   localparam int WORD_W     = 64;
   localparam int NUM_WORDS  = (DOTS_PER_ROW + WORD_W - 1) / WORD_W;
   localparam int HALF_WIDTH = (GRAPH_RIGHT_DOT - GRAPH_LEFT_DOT) / 2;
   localparam int MARK_DOT_A = 12;
   localparam int MARK_DOT_B = 13;

   // field widths
   localparam int BIN_W    = 16;
   localparam int FS_W     = 31;
   localparam int LIMIT_W  = 12;
   localparam int COUNT_W  = 12;
   localparam int WIDX_W   = 3;
   localparam int ROW_W    = 11;
   localparam int COUNTER_MAX = 4095;

   // derived arithmetic widths
   localparam int PROD_W = BIN_W + $clog2(HALF_WIDTH + 1);
   localparam int MAG_W  = PROD_W - 1;
   localparam int POS_W  = PROD_W + 2;
   localparam int STEP_W = $clog2(MAG_W);
   localparam int DOT_W  = $clog2(NUM_WORDS * WORD_W);

   typedef enum logic {
      CSR_FULL_SCALE = 1'b0,
      CSR_ROW_LIMIT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_hi;
      logic span;
      logic order;
      logic word_load;
   } trr_cmd_type;

   typedef struct packed {
      logic row_active;
      logic div_done;
      logic last_word;
   } trr_stat_type;

endpackage

>>> hdl/trr_divider.sv
`timescale 1ns / 1ps

module trr_divider (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [trr_pkg::PROD_W-1:0]       dividend,
   input  logic        [trr_pkg::FS_W-1:0]         divisor,
   output logic signed [trr_pkg::PROD_W-1:0]       quotient,
   output logic                                    done
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [trr_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [trr_pkg::MAG_W-1:0]      dvd_ff, dvd_in;
   logic [trr_pkg::FS_W-1:0]       rem_ff, rem_in;
   logic [trr_pkg::FS_W-1:0]       dsr_ff, dsr_in;
   logic                           neg_ff, neg_in;
   logic [trr_pkg::FS_W:0]         trial;
   logic [trr_pkg::MAG_W-1:0]      mag_abs;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, dvd_ff[trr_pkg::MAG_W-1]};
      mag_abs = trr_pkg::MAG_W'(dividend[trr_pkg::PROD_W-1] ? -dividend : dividend);
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = mag_abs;
         rem_in  = '0;
         // zero full scale divides as one
         dsr_in  = (divisor == '0) ? trr_pkg::FS_W'(1) : divisor;
         neg_in  = dividend[trr_pkg::PROD_W-1];
      end else if (busy_ff) begin
         // restoring step, quotient bits shift into the dividend register
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trr_pkg::FS_W'(trial - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[trr_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[trr_pkg::FS_W-1:0];
            dvd_in = {dvd_ff[trr_pkg::MAG_W-2:0], 1'b0};
         end
         if (step_ff == trr_pkg::STEP_W'(trr_pkg::MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
   end

   assign quotient = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
   assign done     = done_ff;

endmodule

>>> hdl/trr_datapath.sv
`timescale 1ns / 1ps

module trr_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  trr_pkg::trr_cmd_type               cmd,
   output trr_pkg::trr_stat_type              stat,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [trr_pkg::FS_W-1:0]           csr_wdata,
   input  logic [2*trr_pkg::BIN_W-1:0]        req_tdata,
   input  logic                               req_tlast,
   output logic [trr_pkg::WORD_W-1:0]         rsp_tdata,
   output logic [15:0]                        rsp_tuser,
   output logic                               rsp_tlast
);

   localparam logic signed [trr_pkg::PROD_W-1:0] HW_P  = trr_pkg::PROD_W'(trr_pkg::HALF_WIDTH);
   localparam logic signed [trr_pkg::PROD_W-1:0] NHW_P = -HW_P;
   localparam logic signed [trr_pkg::POS_W-1:0]  CENTRE_S =
      trr_pkg::POS_W'(trr_pkg::GRAPH_CENTRE_DOT);
   localparam logic signed [trr_pkg::POS_W-1:0]  LAST_DOT_S =
      trr_pkg::POS_W'(trr_pkg::DOTS_PER_ROW - 1);
   localparam logic [trr_pkg::LIMIT_W-1:0] ROW_CAP = trr_pkg::LIMIT_W'(trr_pkg::MAX_ROW_COUNT);

   logic [trr_pkg::FS_W-1:0]          full_scale_ff;
   logic [trr_pkg::LIMIT_W-1:0]       row_limit_ff;
   logic [trr_pkg::COUNT_W-1:0]       counter_ff, counter_in;
   logic [trr_pkg::ROW_W-1:0]         row_ff;
   logic                              active_ff;
   logic signed [trr_pkg::PROD_W-1:0] p_lo_ff, p_hi_ff;
   logic signed [trr_pkg::PROD_W-1:0] lo_ff, hi_ff;
   logic                              sel_ff;
   logic                              clip_ff;
   logic signed [trr_pkg::POS_W-1:0]  x0_ff, x1_ff;
   logic [trr_pkg::DOT_W-1:0]         s_lo_ff, s_hi_ff;
   logic                              empty_ff;
   logic [trr_pkg::WIDX_W-1:0]        w_ff;
   logic [trr_pkg::WORD_W-1:0]        word_ff;
   logic [trr_pkg::WIDX_W-1:0]        widx_ff;
   logic                              oclip_ff;
   logic                              olast_ff;

   logic [trr_pkg::LIMIT_W-1:0]       limit;
   logic signed [trr_pkg::PROD_W-1:0] bmin_x, bmax_x;
   logic signed [trr_pkg::PROD_W-1:0] div_a;
   logic signed [trr_pkg::PROD_W-1:0] quo;
   logic                              div_done;
   logic signed [trr_pkg::PROD_W-1:0] lo_c, hi_c;
   logic signed [trr_pkg::POS_W-1:0]  x1e, a, b;
   logic [trr_pkg::WORD_W-1:0]        word_bits;
   logic [trr_pkg::DOT_W-1:0]         dot;

   trr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (full_scale_ff),
      .quotient (quo),
      .done     (div_done)
   );

   assign limit  = (row_limit_ff > ROW_CAP) ? ROW_CAP : row_limit_ff;
   assign bmin_x = trr_pkg::PROD_W'($signed(req_tdata[trr_pkg::BIN_W-1:0]));
   assign bmax_x = trr_pkg::PROD_W'($signed(req_tdata[2*trr_pkg::BIN_W-1:trr_pkg::BIN_W]));
   assign div_a  = cmd.div_hi ? p_hi_ff : p_lo_ff;

   always_comb begin
      if (req_tlast)
         counter_in = '0;
      else if (counter_ff < trr_pkg::COUNT_W'(trr_pkg::COUNTER_MAX))
         counter_in = counter_ff + 1'b1;
      else
         counter_in = counter_ff;
   end

   // clamp low bound from below and high bound from above only
   always_comb begin
      lo_c = (lo_ff < NHW_P) ? NHW_P : lo_ff;
      hi_c = (hi_ff > HW_P) ? HW_P : hi_ff;
   end

   always_comb begin
      x1e = (x0_ff == x1_ff) ? x0_ff + 1'b1 : x1_ff;
      if (x0_ff > x1e) begin
         a = x1e;
         b = x0_ff;
      end else begin
         a = x0_ff;
         b = x1e;
      end
   end

   always_comb begin
      word_bits = '0;
      dot       = '0;
      for (int j = 0; j < trr_pkg::WORD_W; j++) begin
         dot = trr_pkg::DOT_W'({w_ff, 6'(j)});
         if (int'(dot) < trr_pkg::DOTS_PER_ROW) begin
            if ((!empty_ff && dot >= s_lo_ff && dot <= s_hi_ff) ||
                (clip_ff && (dot == trr_pkg::DOT_W'(trr_pkg::MARK_DOT_A) ||
                             dot == trr_pkg::DOT_W'(trr_pkg::MARK_DOT_B))))
               word_bits[trr_pkg::WORD_W-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= trr_pkg::FS_W'(32767);
         row_limit_ff  <= trr_pkg::LIMIT_W'(2048);
         counter_ff    <= '0;
         active_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               trr_pkg::CSR_FULL_SCALE: full_scale_ff <= csr_wdata;
               trr_pkg::CSR_ROW_LIMIT:  row_limit_ff  <= csr_wdata[trr_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            counter_ff <= counter_in;
            active_ff  <= counter_ff < limit;
         end
      end

      if (cmd.load) begin
         row_ff  <= counter_ff[trr_pkg::ROW_W-1:0];
         p_lo_ff <= bmin_x * HW_P;
         p_hi_ff <= bmax_x * HW_P;
      end
      if (cmd.div_start)
         sel_ff <= cmd.div_hi;
      if (div_done) begin
         if (sel_ff)
            hi_ff <= quo;
         else
            lo_ff <= quo;
      end
      if (cmd.span) begin
         clip_ff <= (lo_ff < NHW_P) || (hi_ff > HW_P);
         x0_ff   <= trr_pkg::POS_W'(lo_c) + CENTRE_S;
         x1_ff   <= trr_pkg::POS_W'(hi_c) + CENTRE_S;
      end
      if (cmd.order) begin
         empty_ff <= (a > LAST_DOT_S) || (b < 0);
         s_lo_ff  <= (a < 0) ? '0 : a[trr_pkg::DOT_W-1:0];
         s_hi_ff  <= (b > LAST_DOT_S) ? LAST_DOT_S[trr_pkg::DOT_W-1:0] : b[trr_pkg::DOT_W-1:0];
         w_ff     <= '0;
      end
      if (cmd.word_load) begin
         word_ff  <= word_bits;
         widx_ff  <= w_ff;
         oclip_ff <= clip_ff;
         olast_ff <= (w_ff == trr_pkg::WIDX_W'(trr_pkg::NUM_WORDS - 1));
         w_ff     <= w_ff + 1'b1;
      end
   end

   assign stat.row_active = active_ff;
   assign stat.div_done   = div_done;
   assign stat.last_word  = olast_ff;

   assign rsp_tdata = word_ff;
   assign rsp_tuser = {1'b0, oclip_ff, row_ff, widx_ff};
   assign rsp_tlast = olast_ff;

endmodule

>>> hdl/trr_ctrl.sv
`timescale 1ns / 1ps

module trr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output trr_pkg::trr_cmd_type  cmd,
   input  trr_pkg::trr_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_LO,
      S_DIV_HI,
      S_SPAN,
      S_ORDER,
      S_FILL,
      S_SEND
   } state_type;

   state_type state_ff;
   logic      valid_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:   cmd.load = req_tvalid;
         S_CHECK:  cmd.div_start = stat.row_active;
         S_DIV_LO: begin
            cmd.div_start = stat.div_done;
            cmd.div_hi    = 1'b1;
         end
         S_SPAN:   cmd.span = 1'b1;
         S_ORDER:  cmd.order = 1'b1;
         S_FILL:   cmd.word_load = 1'b1;
         S_SEND:   cmd.word_load = rsp_tready && !stat.last_word;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid)
                  state_ff <= S_CHECK;
            end
            S_CHECK: begin
               // rows past the limit only advance the counter
               state_ff <= stat.row_active ? S_DIV_LO : S_IDLE;
            end
            S_DIV_LO: begin
               if (stat.div_done)
                  state_ff <= S_DIV_HI;
            end
            S_DIV_HI: begin
               if (stat.div_done)
                  state_ff <= S_SPAN;
            end
            S_SPAN:  state_ff <= S_ORDER;
            S_ORDER: state_ff <= S_FILL;
            S_FILL: begin
               valid_ff <= 1'b1;
               state_ff <= S_SEND;
            end
            S_SEND: begin
               if (rsp_tready && stat.last_word) begin
                  valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> hdl/trace_row_rasterizer.sv
`timescale 1ns / 1ps
// channel   direction  tdata                               tuser / tlast
// req       in         [15:0] bin_min, [31:16] bin_max     tlast = last_bin
// rsp       out        [63:0] row_word                     tuser [2:0] word_index,
//                                                          [13:3] row_index, [14] clipped;
//                                                          tlast = last_word
// csr       in         csr_we, csr_index (0 full_scale, 1 row_limit), csr_wdata
//
// one request at a time: a drawn row runs the serial divider for each of the two
// bounds, then the span and order steps, then 6 output words; a row past the limit
// only advances the row counter. sync reset restores full_scale 32767, row_limit
// 2048 and the row counter to 0. a stalled rsp holds the word and the block takes
// no request.

module trace_row_rasterizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [trr_pkg::FS_W-1:0]          csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*trr_pkg::BIN_W-1:0]       req_tdata,   // bin_min, bin_max
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [trr_pkg::WORD_W-1:0]        rsp_tdata,   // row_word
   output logic [15:0]                       rsp_tuser,   // word_index, row_index, clipped
   output logic                              rsp_tlast
);

   trr_pkg::trr_cmd_type  cmd;
   trr_pkg::trr_stat_type stat;

   trr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   trr_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

>>> sim/trr_row_checker.sv
`timescale 1ns / 1ps

module trr_row_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [trr_pkg::FS_W-1:0]           csr_wdata,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [2*trr_pkg::BIN_W-1:0]        req_tdata,   // bin_min, bin_max
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [trr_pkg::WORD_W-1:0]         rsp_tdata,   // row_word
   input  logic [15:0]                        rsp_tuser,   // word_index, row_index, clipped
   input  logic                               rsp_tlast,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 words_checked
);

   localparam int     ROW_BITS  = trr_pkg::NUM_WORDS * trr_pkg::WORD_W;
   localparam longint SPAN_HALF = (trr_pkg::GRAPH_RIGHT_DOT - trr_pkg::GRAPH_LEFT_DOT) / 2;

   typedef struct packed {
      logic [trr_pkg::WORD_W-1:0] dots;
      logic [trr_pkg::WIDX_W-1:0] word_idx;
      logic [trr_pkg::ROW_W-1:0]  row;
      logic                       clipped;
      logic                       last;
   } row_word_type;

   logic [trr_pkg::FS_W-1:0]    scale_q;
   logic [trr_pkg::LIMIT_W-1:0] limit_q;
   logic [trr_pkg::COUNT_W-1:0] row_ctr;
   row_word_type                pending_words[$];

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   // dot 0 sits in the top bit so each word is a plain slice
   function automatic logic [ROW_BITS-1:0] draw_row(input logic [trr_pkg::BIN_W-1:0] lo_bin,
                                                    input logic [trr_pkg::BIN_W-1:0] hi_bin,
                                                    input logic [trr_pkg::FS_W-1:0] scale,
                                                    output logic clip);
      longint fs, lo, hi, x0, x1, t, x;
      logic [ROW_BITS-1:0] dots;
      if (scale == 0)
         fs = 1;
      else
         fs = longint'(scale);
      lo = longint'($signed(lo_bin)) * SPAN_HALF / fs;
      hi = longint'($signed(hi_bin)) * SPAN_HALF / fs;
      clip = (lo < -SPAN_HALF) || (hi > SPAN_HALF);
      // low bound only clamps downward, high bound only upward
      if (lo < -SPAN_HALF)
         lo = -SPAN_HALF;
      if (hi > SPAN_HALF)
         hi = SPAN_HALF;
      x0 = trr_pkg::GRAPH_CENTRE_DOT + lo;
      x1 = trr_pkg::GRAPH_CENTRE_DOT + hi;
      if (x0 == x1)
         x1 = x0 + 1;
      if (x0 > x1) begin
         t  = x0;
         x0 = x1;
         x1 = t;
      end
      if (x0 < 0)
         x0 = 0;
      if (x1 > trr_pkg::DOTS_PER_ROW - 1)
         x1 = trr_pkg::DOTS_PER_ROW - 1;
      dots = '0;
      for (x = x0; x <= x1; x++)
         if (x >= 0 && x < trr_pkg::DOTS_PER_ROW)
            dots[ROW_BITS-1-x] = 1'b1;
      if (clip) begin
         dots[ROW_BITS-1-trr_pkg::MARK_DOT_A] = 1'b1;
         dots[ROW_BITS-1-trr_pkg::MARK_DOT_B] = 1'b1;
      end
      return dots;
   endfunction

   always @(posedge clock) begin : watch
      row_word_type        want;
      logic [ROW_BITS-1:0] dots;
      logic                clip;
      int                  lim;
      int                  w;
      if (reset) begin
         scale_q = trr_pkg::FS_W'(32767);
         limit_q = trr_pkg::LIMIT_W'(2048);
         row_ctr = '0;
         pending_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               trr_pkg::CSR_FULL_SCALE: scale_q = csr_wdata;
               trr_pkg::CSR_ROW_LIMIT:  limit_q = csr_wdata[trr_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               note_mismatch("unrequested row word", rsp_tdata, '0);
            end else begin
               want = pending_words.pop_front();
               words_checked++;
               if (rsp_tdata !== want.dots)
                  note_mismatch("row_word", rsp_tdata, want.dots);
               if (rsp_tuser[2:0] !== want.word_idx)
                  note_mismatch("word_index", 64'(rsp_tuser[2:0]), 64'(want.word_idx));
               if (rsp_tuser[13:3] !== want.row)
                  note_mismatch("row_index", 64'(rsp_tuser[13:3]), 64'(want.row));
               if (rsp_tuser[14] !== want.clipped)
                  note_mismatch("clipped", 64'(rsp_tuser[14]), 64'(want.clipped));
               if (rsp_tuser[15] !== 1'b0)
                  note_mismatch("tuser pad bit", 64'(rsp_tuser[15]), '0);
               if (rsp_tlast !== want.last)
                  note_mismatch("last_word", 64'(rsp_tlast), 64'(want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            lim = (limit_q > trr_pkg::MAX_ROW_COUNT) ? trr_pkg::MAX_ROW_COUNT : int'(limit_q);
            if (row_ctr < lim) begin
               dots = draw_row(req_tdata[trr_pkg::BIN_W-1:0],
                               req_tdata[2*trr_pkg::BIN_W-1:trr_pkg::BIN_W], scale_q, clip);
               for (w = 0; w < trr_pkg::NUM_WORDS; w++) begin
                  want.dots     = dots[ROW_BITS-1-w*trr_pkg::WORD_W -: trr_pkg::WORD_W];
                  want.word_idx = trr_pkg::WIDX_W'(w);
                  want.row      = row_ctr[trr_pkg::ROW_W-1:0];
                  want.clipped  = clip;
                  want.last     = (w == trr_pkg::NUM_WORDS - 1);
                  pending_words.push_back(want);
               end
            end
            // counter keeps moving even for rows that draw nothing
            if (req_tlast)
               row_ctr = '0;
            else if (row_ctr != trr_pkg::COUNTER_MAX)
               row_ctr = row_ctr + 1'b1;
         end
      end
      outstanding = pending_words.size();
   end

endmodule

>>> sim/tb_trace_row_rasterizer.sv
`timescale 1ns / 1ps

module tb_trace_row_rasterizer;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           csr_we     = 1'b0;
   logic                           csr_index  = trr_pkg::CSR_FULL_SCALE;
   logic [trr_pkg::FS_W-1:0]       csr_wdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [2*trr_pkg::BIN_W-1:0]    req_tdata  = '0;   // bin_min, bin_max
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [trr_pkg::WORD_W-1:0]     rsp_tdata;         // row_word
   logic [15:0]                    rsp_tuser;         // word_index, row_index, clipped
   logic                           rsp_tlast;

   int mismatches;
   int outstanding;
   int words_checked;

   int requests_sent  = 0;
   int settings_used  = 0;
   int burst_left     = 0;
   int max_gap        = 0;
   int hold_ask       = 0;
   int hold_done      = 0;
   int hold_cycles    = 0;
   int stall_tick     = 0;

   trace_row_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   trr_row_checker row_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // output side: rotating stall patterns, plus a long hold-off when asked
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (hold_ask != hold_done) begin
         rsp_tready <= 1'b0;
         if (hold_cycles == 400) begin
            hold_cycles <= 0;
            hold_done   <= hold_done + 1;
         end else begin
            hold_cycles <= hold_cycles + 1;
         end
      end else begin
         case (stall_tick[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= (stall_tick % 3 == 0);
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d row words still expected", outstanding);
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic configure(input logic [trr_pkg::FS_W-1:0] scale,
                            input logic [trr_pkg::FS_W-1:0] limit_word);
      csr_we    <= 1'b1;
      csr_index <= trr_pkg::CSR_FULL_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_index <= trr_pkg::CSR_ROW_LIMIT;
      csr_wdata <= limit_word;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic send_bin(input logic [trr_pkg::BIN_W-1:0] lo_bin,
                           input logic [trr_pkg::BIN_W-1:0] hi_bin,
                           input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= {hi_bin, lo_bin};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // wait for every expected word, then let a dropped row finish inside the block
   task automatic drain;
      int guard;
      req_tvalid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (outstanding != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   initial begin
      logic [trr_pkg::BIN_W-1:0] a, b;
      logic [trr_pkg::FS_W-1:0]  scale, limit_word;
      int                        sa, p;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: widened zero span, full swing, reversed bounds
      max_gap = 6;
      send_bin(16'd0, 16'd0, 1'b0);
      send_bin(16'h8000, 16'h7FFF, 1'b0);
      send_bin(16'h7FFF, 16'h8000, 1'b0);
      send_bin(-16'sd191, 16'sd191, 1'b0);
      send_bin(16'sd20000, -16'sd20000, 1'b0);
      send_bin(16'hFFFF, 16'hFFFF, 1'b1);
      drain();

      // tiny full scale: both clamps, spans running off either end of the row
      configure(31'd1, 31'd2048);
      send_bin(16'h8000, 16'h8000, 1'b0);
      send_bin(16'h7FFF, 16'h7FFF, 1'b0);
      send_bin(16'sd1, -16'sd1, 1'b0);
      send_bin(16'hFFFF, 16'hFFFF, 1'b0);
      send_bin(16'd0, 16'd0, 1'b1);
      drain();

      // zero full scale behaves as one; limit above the image height
      configure(31'd0, 31'd4095);
      send_bin(16'sd2, -16'sd2, 1'b0);
      send_bin(-16'sd2, 16'sd2, 1'b0);
      drain();

      configure(31'h7FFF_FFFF, 31'd2048);
      send_bin(16'h8000, 16'h7FFF, 1'b1);
      drain();

      // short image: rows past the limit vanish until the trace restarts
      configure(31'd100, 31'd3);
      send_bin(-16'sd1000, 16'sd1000, 1'b0);
      send_bin(-16'sd50, 16'sd150, 1'b0);
      send_bin(16'sd90, 16'sd99, 1'b0);
      send_bin(16'sd7, 16'sd7, 1'b0);
      send_bin(-16'sd300, 16'sd300, 1'b0);
      send_bin(16'sd0, 16'sd0, 1'b1);
      send_bin(-16'sd50, 16'sd50, 1'b0);
      drain();

      for (p = 0; p < 8; p++) begin
         case ($urandom_range(0, 5))
            0: scale = trr_pkg::FS_W'($urandom_range(1, 16));
            1: scale = trr_pkg::FS_W'($urandom_range(17, 1000));
            2: scale = trr_pkg::FS_W'($urandom_range(1000, 40000));
            3: scale = 31'd32767;
            4: scale = trr_pkg::FS_W'($urandom);
            default: scale = trr_pkg::FS_W'($urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 3))
            0, 1: limit_word = 31'd2048;
            2: limit_word = trr_pkg::FS_W'($urandom_range(0, 4095));
            default: limit_word = trr_pkg::FS_W'($urandom_range(1, 40));
         endcase
         // upper write-data bits are not part of the row limit
         limit_word = limit_word | trr_pkg::FS_W'($urandom & 32'h7FFF_F000);
         configure(scale, limit_word);
         max_gap = (p % 3 == 0) ? 0 : 90;
         if (p == 2 || p == 6)
            hold_ask++;
         repeat (45) begin
            case ($urandom_range(0, 7))
               0: begin
                  a = trr_pkg::BIN_W'($urandom);
                  b = trr_pkg::BIN_W'($urandom);
               end
               1: begin
                  a = trr_pkg::BIN_W'($urandom_range(0, 600) - 300);
                  b = trr_pkg::BIN_W'($urandom_range(0, 600) - 300);
               end
               2: begin
                  a = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                  b = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
               end
               default: begin
                  // ordinary bin: max a little above min
                  a  = trr_pkg::BIN_W'($urandom);
                  sa = int'($signed(a));
                  sa = sa + int'($urandom_range(0, 3000));
                  if (sa > 32767)
                     sa = 32767;
                  b = sa[trr_pkg::BIN_W-1:0];
               end
            endcase
            send_bin(a, b, ($urandom_range(0, 15) == 0));
         end
         drain();
      end

      drain();
      $display("sent %0d requests across %0d register settings, %0d row words compared",
               requests_sent, settings_used, words_checked);
      $display("covered clamps on both sides, reversed and equal spans, short images, long stalls");
      if (outstanding != 0)
         $display("%0d row words never came out", outstanding);
      if (mismatches == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
